// File: hw/rtl/ascii_to_integer_parser_macros.svh
// Assertion macros used by the ascii_to_integer_parser checker.
`ifndef ASCII_TO_INTEGER_PARSER_MACROS_SVH
`define ASCII_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define A2I_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define A2I_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/a2i_pkg.sv
// Shared types and constants of the ASCII-to-integer parser.
package a2i_pkg;

    // Width of the result value field
    localparam int OUT_W = 32;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Character codes the front looks for
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Number base in use
    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } t_radix;

    // One classified character, as queued from front to back
    typedef struct packed {
        logic       first;
        logic       space;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       xch;
        logic       dec;
        logic       oct;
        logic       hex;
        logic [3:0] dval;
    } t_tok;

endpackage

// File: hw/rtl/a2i_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface a2i_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       first;

    modport source (output valid, output character, output first, input ready);
    modport sink   (input valid, input character, input first, output ready);
endinterface

interface a2i_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [a2i_pkg::OUT_W-1:0] value;
    logic                             overflowed;
    logic                             digits_seen;

    modport source (output valid, output value, output overflowed, output digits_seen,
                    input ready);
    modport sink   (input valid, input value, input overflowed, input digits_seen,
                    output ready);
endinterface

// File: hw/rtl/a2i_front.sv
// Front end: accepts characters and classifies each into a token.
module a2i_front (
    a2i_in_if.sink         i_chr,
    input  logic           i_q_full,
    output logic           o_push,
    output a2i_pkg::t_tok  o_tok
);

    logic [7:0] c;

    assign c            = i_chr.character;
    assign i_chr.ready  = !i_q_full;
    assign o_push       = i_chr.valid && !i_q_full;

    // Classify the character and extract its digit value
    always_comb begin
        o_tok       = '0;
        o_tok.first = i_chr.first;
        o_tok.space = (c == a2i_pkg::CH_SPACE) || (c inside {[a2i_pkg::CH_TAB:a2i_pkg::CH_CR]});
        o_tok.plus  = (c == a2i_pkg::CH_PLUS);
        o_tok.minus = (c == a2i_pkg::CH_MINUS);
        o_tok.zero  = (c == a2i_pkg::CH_ZERO);
        o_tok.xch   = (c == a2i_pkg::CH_LO_X) || (c == a2i_pkg::CH_UP_X);
        o_tok.dec   = c inside {[a2i_pkg::CH_ZERO:a2i_pkg::CH_NINE]};
        o_tok.oct   = c inside {[a2i_pkg::CH_ZERO:a2i_pkg::CH_SEVEN]};
        if (c inside {[a2i_pkg::CH_ZERO:a2i_pkg::CH_NINE]}) begin
            o_tok.hex  = 1'b1;
            o_tok.dval = 4'(c - a2i_pkg::CH_ZERO);
        end else if (c inside {[a2i_pkg::CH_UP_A:a2i_pkg::CH_UP_F]}) begin
            o_tok.hex  = 1'b1;
            o_tok.dval = 4'(c - a2i_pkg::CH_UP_A + 8'd10);
        end else if (c inside {[a2i_pkg::CH_LO_A:a2i_pkg::CH_LO_F]}) begin
            o_tok.hex  = 1'b1;
            o_tok.dval = 4'(c - a2i_pkg::CH_LO_A + 8'd10);
        end
    end

endmodule

// File: hw/rtl/a2i_queue.sv
// Short token queue that decouples the front from the back.
module a2i_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  a2i_pkg::t_tok  i_tok,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output a2i_pkg::t_tok  o_tok
);

    a2i_pkg::t_tok                  r_mem [a2i_pkg::Q_DEPTH];
    logic [a2i_pkg::Q_PTR_W-1:0]    r_wr;
    logic [a2i_pkg::Q_PTR_W-1:0]    r_rd;
    logic [a2i_pkg::Q_CNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == a2i_pkg::Q_CNT_W'(a2i_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store tokens; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == a2i_pkg::Q_PTR_W'(a2i_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == a2i_pkg::Q_PTR_W'(a2i_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/a2i_back.sv
// Back end: runs the parse on tokens and registers each finished result.
module a2i_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  a2i_pkg::t_tok  i_tok,
    output logic           o_pop,
    a2i_out_if.source      o_res
);

    localparam int W = VALUE_WIDTH;

    // Saturation limits and overflow cut points per base and sign
    localparam logic [W-1:0] LIM_P   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_N   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] CUT_PD  = W'(LIM_P / 10);
    localparam logic [W-1:0] CUT_ND  = W'(LIM_N / 10);
    localparam logic [W-1:0] CUT_PO  = W'(LIM_P / 8);
    localparam logic [W-1:0] CUT_NO  = W'(LIM_N / 8);
    localparam logic [W-1:0] CUT_PH  = W'(LIM_P / 16);
    localparam logic [W-1:0] CUT_NH  = W'(LIM_N / 16);
    localparam logic [3:0]   CL_PD   = 4'(LIM_P % 10);
    localparam logic [3:0]   CL_ND   = 4'(LIM_N % 10);
    localparam logic [3:0]   CL_PO   = 4'(LIM_P % 8);
    localparam logic [3:0]   CL_NO   = 4'(LIM_N % 8);
    localparam logic [3:0]   CL_PH   = 4'(LIM_P % 16);
    localparam logic [3:0]   CL_NH   = 4'(LIM_N % 16);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic              r_neg,    n_neg;
    a2i_pkg::t_radix   r_radix,  n_radix;
    logic [W-1:0]      r_acc,    n_acc;
    logic              r_ovf,    n_ovf;
    logic              r_any,    n_any;
    logic              r_out_valid;
    logic [a2i_pkg::OUT_W-1:0] r_out_value;
    logic              r_out_ovf;
    logic              r_out_any;

    t_phase            e_phase;
    logic              e_neg;
    a2i_pkg::t_radix   e_radix;
    logic [W-1:0]      e_acc;
    logic              e_ovf;
    logic              e_any;
    a2i_pkg::t_radix   a_rad;
    logic [W-1:0]      cut;
    logic [3:0]        cutlim;
    logic [W-1:0]      step_acc;
    logic              step_ovf;
    logic              lead;
    logic              emit;
    logic [W-1:0]      fin;
    logic [a2i_pkg::OUT_W-1:0] fin_out;

    assign o_pop = i_q_valid && (!r_out_valid || o_res.ready);

    // Start of a new string drops the parse in progress
    always_comb begin
        if (i_tok.first) begin
            e_phase = PH_SPACE;
            e_neg   = 1'b0;
            e_radix = a2i_pkg::RX_DEC;
            e_acc   = '0;
            e_ovf   = 1'b0;
            e_any   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_neg   = r_neg;
            e_radix = r_radix;
            e_acc   = r_acc;
            e_ovf   = r_ovf;
            e_any   = r_any;
        end
    end

    // After a sign, or on a non-space non-sign character before one, take the leading-digit path
    assign lead = (e_phase == PH_SIGNED) ||
                  ((e_phase == PH_SPACE) && !i_tok.space && !i_tok.plus && !i_tok.minus);

    // Pick the base that a digit here would be taken in
    always_comb begin
        if (lead) begin
            a_rad = a2i_pkg::RX_DEC;
        end else if (e_phase == PH_ZERO) begin
            a_rad = a2i_pkg::RX_OCT;
        end else begin
            a_rad = e_radix;
        end
    end

    // Select cut point for base and sign
    always_comb begin
        case (a_rad)
            a2i_pkg::RX_OCT: begin
                cut    = e_neg ? CUT_NO : CUT_PO;
                cutlim = e_neg ? CL_NO  : CL_PO;
            end
            a2i_pkg::RX_HEX: begin
                cut    = e_neg ? CUT_NH : CUT_PH;
                cutlim = e_neg ? CL_NH  : CL_PH;
            end
            default: begin
                cut    = e_neg ? CUT_ND : CUT_PD;
                cutlim = e_neg ? CL_ND  : CL_PD;
            end
        endcase
    end

    // Multiply by the base with shifts and add the digit
    always_comb begin
        case (a_rad)
            a2i_pkg::RX_OCT: step_acc = (e_acc << 3) + W'(i_tok.dval);
            a2i_pkg::RX_HEX: step_acc = (e_acc << 4) + W'(i_tok.dval);
            default:         step_acc = (e_acc << 3) + (e_acc << 1) + W'(i_tok.dval);
        endcase
        step_ovf = e_ovf || (e_acc > cut) || ((e_acc == cut) && (i_tok.dval > cutlim));
    end

    // Parse step
    always_comb begin
        n_phase = e_phase;
        n_neg   = e_neg;
        n_radix = e_radix;
        n_acc   = e_acc;
        n_ovf   = e_ovf;
        n_any   = e_any;
        emit    = 1'b0;
        if (lead) begin
            if (i_tok.zero) begin
                n_any   = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                n_radix = a2i_pkg::RX_DEC;
                if (i_tok.dec) begin
                    n_any   = 1'b1;
                    n_ovf   = step_ovf;
                    n_acc   = step_ovf ? e_acc : step_acc;
                    n_phase = PH_DIGITS;
                end else begin
                    emit = 1'b1;
                end
            end
        end else begin
            case (e_phase)
                PH_SPACE: begin
                    if (i_tok.plus || i_tok.minus) begin
                        n_neg   = i_tok.minus;
                        n_phase = PH_SIGNED;
                    end
                end
                PH_ZERO: begin
                    if (i_tok.xch) begin
                        n_radix = a2i_pkg::RX_HEX;
                        n_phase = PH_HEXPFX;
                    end else begin
                        n_radix = a2i_pkg::RX_OCT;
                        n_phase = PH_DIGITS;
                        if (i_tok.oct) begin
                            n_any = 1'b1;
                            n_ovf = step_ovf;
                            n_acc = step_ovf ? e_acc : step_acc;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
                PH_HEXPFX: begin
                    if (i_tok.hex) begin
                        n_any   = 1'b1;
                        n_ovf   = step_ovf;
                        n_acc   = step_ovf ? e_acc : step_acc;
                        n_phase = PH_DIGITS;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if ((e_radix == a2i_pkg::RX_HEX) ? i_tok.hex :
                        (e_radix == a2i_pkg::RX_OCT) ? i_tok.oct : i_tok.dec) begin
                        n_any = 1'b1;
                        n_ovf = step_ovf;
                        n_acc = step_ovf ? e_acc : step_acc;
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    // Form the final value: saturate or apply the sign
    always_comb begin
        if (e_ovf) begin
            fin = e_neg ? LIM_N : LIM_P;
        end else begin
            fin = e_neg ? (~e_acc + 1'b1) : e_acc;
        end
    end

    generate
        if (W >= a2i_pkg::OUT_W) begin : g_trunc
            assign fin_out = fin[a2i_pkg::OUT_W-1:0];
        end else begin : g_zext
            assign fin_out = {{(a2i_pkg::OUT_W-W){1'b0}}, fin};
        end
    endgenerate

    // Hold parse state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_neg       <= 1'b0;
            r_radix     <= a2i_pkg::RX_DEC;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_ovf   <= 1'b0;
            r_out_any   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_any   <= n_any;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
                r_out_value <= fin_out;
                r_out_ovf   <= e_ovf;
                r_out_any   <= e_any;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.value       = r_out_value;
    assign o_res.overflowed  = r_out_ovf;
    assign o_res.digits_seen = r_out_any;

endmodule

// File: hw/rtl/ascii_to_integer_parser.sv
// Top level of the ASCII-to-integer parser: front, token queue and back.
//
//  channel  | dir | word                                   | handshake
//  i_chr    | in  | character[7:0], first                  | valid/ready
//  o_res    | out | value[31:0] signed, overflowed, digits | valid/ready
//
// One character per cycle is taken while the output keeps up.
// Each token is registered in the queue, then its result in the back's result register.
// A two-entry token queue lets the front keep accepting while a result waits.
// Reset is synchronous; no clearing pass follows.
// A stalled result holds the back; the front stalls once the queue is full.
module ascii_to_integer_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    a2i_in_if.sink    i_chr,
    a2i_out_if.source o_res
);

    a2i_pkg::t_tok  front_tok;
    a2i_pkg::t_tok  q_tok;
    logic           front_push;
    logic           q_full;
    logic           q_valid;
    logic           back_pop;

    a2i_front u_front (
        .i_chr    (i_chr),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_tok    (front_tok)
    );

    a2i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_tok   (front_tok),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    a2i_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (q_tok),
        .o_pop     (back_pop),
        .o_res     (o_res)
    );

endmodule

// File: hw/rtl/a2i_chk.sv
// Port checker for the ASCII-to-integer parser, bound to the top level.
`include "ascii_to_integer_parser_macros.svh"

module a2i_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [a2i_pkg::OUT_W-1:0]         i_out_value,
    input logic                              i_out_ovf,
    input logic                              i_out_any
);

    // A stalled result word holds
    `A2I_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_ovf) && $stable(i_out_any), "result word changed while stalled")

    // Overflow only comes from consumed digits
    `A2I_ASSERT_NOW(a_ovf_digits, i_clk, i_rst_n, i_out_valid && i_out_ovf, i_out_any, "overflow without digits")

    // No digits gives a plain zero
    `A2I_ASSERT_NOW(a_no_digits_zero, i_clk, i_rst_n, i_out_valid && !i_out_any, (i_out_value == '0) && !i_out_ovf, "nonzero result without digits")

endmodule

bind ascii_to_integer_parser a2i_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.value),
    .i_out_ovf   (o_res.overflowed),
    .i_out_any   (o_res.digits_seen)
);
